[sv/x86mov_pkg.sv]
package x86mov_pkg;

  typedef enum logic [2:0] {
    FORM_RM_REG     = 3'd0,
    FORM_IMM_TO_RM  = 3'd1,
    FORM_IMM_TO_REG = 3'd2,
    FORM_MEM_TO_ACC = 3'd3,
    FORM_ACC_TO_MEM = 3'd4
  } form_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_UNKNOWN = 1'b1;

  localparam logic [1:0] MOD_MEM_NO_DISP = 2'd0;
  localparam logic [1:0] MOD_MEM_DISP8   = 2'd1;
  localparam logic [1:0] MOD_MEM_DISP16  = 2'd2;
  localparam logic [1:0] MOD_REG         = 2'd3;

  localparam logic [2:0] RM_DIRECT = 3'd6;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
  } insn_t;

  typedef struct packed {
    logic        status;
    form_t       form;
    logic        wide;
    logic        reg_is_dest;
    logic [3:0]  reg_index;
    logic [1:0]  mode;
    logic [2:0]  rm_field;
    logic        is_direct;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  length;
  } decode_t;

endpackage

[sv/x86_16_mov_decoder.sv]
// path: an accepted instruction passes the input register, then is decoded into the
// result register; throughput: one instruction per cycle unless result_stall holds
// a result; the decode is a single pass of logic between the two registers, and the
// input register, when empty, refills while a result waits
// reset: synchronous active-high rst empties both stages; payload is not cleared
module x86_16_mov_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  byte0,
  input  logic [7:0]  byte1,
  input  logic [7:0]  byte2,
  input  logic [7:0]  byte3,
  input  logic [7:0]  byte4,
  input  logic [7:0]  byte5,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        status,
  output logic [2:0]  form,
  output logic        wide,
  output logic        reg_is_dest,
  output logic [3:0]  reg_index,
  output logic [1:0]  mode,
  output logic [2:0]  rm_field,
  output logic        is_direct,
  output logic [15:0] displacement,
  output logic [15:0] immediate,
  output logic [2:0]  length
);

  logic                 s1_valid;
  x86mov_pkg::insn_t    s1;
  x86mov_pkg::decode_t  dec;
  x86mov_pkg::decode_t  res;
  logic                 s2_ready;
  logic                 s1_ready;

  logic [1:0]  b1_mod;
  logic [2:0]  b1_rm;
  logic [15:0] rm_disp;
  logic        rm_direct;
  logic [1:0]  rm_bytes;
  logic [15:0] rm_imm;

  assign s2_ready   = !result_valid || !result_stall;
  assign s1_ready   = !s1_valid || s2_ready;
  assign item_stall = !s1_ready;

  // mod/rm operand and the immediate that follows it
  always_comb begin
    b1_mod    = s1.byte1[7:6];
    b1_rm     = s1.byte1[2:0];
    rm_disp   = 16'h0000;
    rm_direct = 1'b0;
    rm_bytes  = 2'd0;
    case (b1_mod)
      x86mov_pkg::MOD_MEM_NO_DISP: begin
        if (b1_rm == x86mov_pkg::RM_DIRECT) begin
          rm_direct = 1'b1;
          rm_disp   = {s1.byte3, s1.byte2};
          rm_bytes  = 2'd2;
        end
      end
      x86mov_pkg::MOD_MEM_DISP8: begin
        rm_disp  = {{8{s1.byte2[7]}}, s1.byte2};
        rm_bytes = 2'd1;
      end
      x86mov_pkg::MOD_MEM_DISP16: begin
        rm_disp  = {s1.byte3, s1.byte2};
        rm_bytes = 2'd2;
      end
      default: begin
      end
    endcase
    case (rm_bytes)
      2'd0:    rm_imm = {s1.byte3, s1.byte2};
      2'd1:    rm_imm = {s1.byte4, s1.byte3};
      default: rm_imm = {s1.byte5, s1.byte4};
    endcase
  end

  always_comb begin
    dec        = '0;
    dec.status = x86mov_pkg::STATUS_OK;
    dec.form   = x86mov_pkg::FORM_RM_REG;
    unique case (s1.byte0) inside
      [8'h88:8'h8B]: begin
        dec.form         = x86mov_pkg::FORM_RM_REG;
        dec.wide         = s1.byte0[0];
        dec.reg_is_dest  = s1.byte0[1];
        dec.mode         = b1_mod;
        dec.rm_field     = b1_rm;
        dec.reg_index    = {s1.byte0[0], s1.byte1[5:3]};
        dec.displacement = rm_disp;
        dec.is_direct    = rm_direct;
        dec.length       = 3'd2 + {1'b0, rm_bytes};
      end
      8'hC6, 8'hC7: begin
        dec.form         = x86mov_pkg::FORM_IMM_TO_RM;
        dec.wide         = s1.byte0[0];
        dec.mode         = b1_mod;
        dec.rm_field     = b1_rm;
        dec.displacement = rm_disp;
        dec.is_direct    = rm_direct;
        dec.immediate    = s1.byte0[0] ? rm_imm : {8'h00, rm_imm[7:0]};
        dec.length       = 3'd3 + {1'b0, rm_bytes} + {2'b00, s1.byte0[0]};
      end
      [8'hB0:8'hBF]: begin
        dec.form        = x86mov_pkg::FORM_IMM_TO_REG;
        dec.wide        = s1.byte0[3];
        dec.reg_is_dest = 1'b1;
        dec.reg_index   = s1.byte0[3:0];
        dec.immediate   = s1.byte0[3] ? {s1.byte2, s1.byte1} : {8'h00, s1.byte1};
        dec.length      = 3'd2 + {2'b00, s1.byte0[3]};
      end
      [8'hA0:8'hA3]: begin
        // bit 1 picks the direction: set means accumulator to memory
        dec.form         = s1.byte0[1] ? x86mov_pkg::FORM_ACC_TO_MEM
                                       : x86mov_pkg::FORM_MEM_TO_ACC;
        dec.wide         = s1.byte0[0];
        dec.reg_is_dest  = !s1.byte0[1];
        dec.reg_index    = {s1.byte0[0], 3'b000};
        dec.is_direct    = 1'b1;
        dec.displacement = {s1.byte2, s1.byte1};
        dec.length       = 3'd3;
      end
      default: begin
        dec.status = x86mov_pkg::STATUS_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= item_valid;
      end
      if (s2_ready) begin
        result_valid <= s1_valid;
      end
    end
    if (s1_ready && item_valid) begin
      s1 <= '{byte0: byte0, byte1: byte1, byte2: byte2,
              byte3: byte3, byte4: byte4, byte5: byte5};
    end
    if (s2_ready && s1_valid) begin
      res <= dec;
    end
  end

  assign status       = res.status;
  assign form         = 3'(res.form);
  assign wide         = res.wide;
  assign reg_is_dest  = res.reg_is_dest;
  assign reg_index    = res.reg_index;
  assign mode         = res.mode;
  assign rm_field     = res.rm_field;
  assign is_direct    = res.is_direct;
  assign displacement = res.displacement;
  assign immediate    = res.immediate;
  assign length       = res.length;

  // unknown opcode carries nothing but its status
  a_unknown_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == x86mov_pkg::STATUS_UNKNOWN |->
      length == 3'd0 && form == 3'd0 && displacement == 16'h0000 && immediate == 16'h0000)
    else $error("unknown opcode result not cleared");

  a_known_length: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == x86mov_pkg::STATUS_OK |-> length >= 3'd2 && length <= 3'd6)
    else $error("decoded length out of range");

  // a stalled input only happens with a full first stage behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid && result_stall)
    else $error("input stalled without a blocked pipeline");

  // a full first stage moves into the result register on the next cycle when unblocked
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> result_valid)
    else $error("first stage did not advance");

endmodule
